/* rtl/dvs_pkg.sv */
// Shared types and codes of the distinct value sorter.
// Holds the transaction payload structs, the status codes and the cell operations.
// Depends on nothing; every other file of the block imports it.
package dvs_pkg;

    localparam int unsigned VALUE_W  = 31;
    localparam int unsigned STATUS_W = 2;

    // Status codes carried in a result.
    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_DUPLICATE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_CAPACITY  = 2'd2;

    // Input transaction payload.
    typedef struct packed {
        logic [VALUE_W-1:0] sample_value;
        logic               end_of_set;
    } in_item_t;

    // Output transaction payload.
    typedef struct packed {
        logic [VALUE_W-1:0]  sorted_value;
        logic [STATUS_W-1:0] status;
        logic                last_out;
    } out_item_t;

    // Contents of one storage cell.
    typedef struct packed {
        logic               valid;
        logic [VALUE_W-1:0] value;
    } entry_t;

    // Operation applied to every cell of the chain at once.
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_SHIFT,
        CELL_CLEAR
    } cell_op_t;

endpackage

/* rtl/dvs_cell.sv */
// One cell of the sorted insertion chain: holds a single value and its valid flag.
// Talks to its two neighbors only; depends on dvs_pkg for entry_t and cell_op_t.
module dvs_cell (
    input  logic                    clk,
    input  logic                    rst_n,
    input  dvs_pkg::cell_op_t       op,
    input  logic [dvs_pkg::VALUE_W-1:0] sample_value,
    input  dvs_pkg::entry_t         prev_entry,
    input  logic                    prev_after,
    input  dvs_pkg::entry_t         next_entry,
    output dvs_pkg::entry_t         entry,
    output logic                    after,
    output logic                    equal
);
    import dvs_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;

    // This cell lies past the insertion point when it is empty or holds a greater value.
    assign after = !valid_reg || (value_reg > sample_value);
    assign equal = valid_reg && (value_reg == sample_value);

    assign entry.valid = valid_reg;
    assign entry.value = value_reg;

    // Next contents: keep, take the new value, take the left neighbor, take the right one, or clear.
    always_comb
    begin
        valid_next = valid_reg;
        value_next = value_reg;
        unique case (op)
            CELL_HOLD:
            begin
                valid_next = valid_reg;
            end
            CELL_INSERT:
            begin
                if (after)
                begin
                    if (prev_after)
                    begin
                        valid_next = prev_entry.valid;
                        value_next = prev_entry.value;
                    end
                    else
                    begin
                        valid_next = 1'b1;
                        value_next = sample_value;
                    end
                end
            end
            CELL_SHIFT:
            begin
                valid_next = next_entry.valid;
                value_next = next_entry.value;
            end
            CELL_CLEAR:
            begin
                valid_next = 1'b0;
            end
            default:
            begin
                valid_next = valid_reg;
            end
        endcase
    end

    // The valid flag is control state and is cleared by reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // The value itself is payload and needs no reset.
    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

endmodule

/* rtl/distinct_value_sorter_core.sv */
// Distinct value sorter: a chain of insertion cells kept in ascending order.
// An accepted value takes its place in the chain at the accepting edge. The first
// result of a set is loaded once the closing value has turned the state to drain and
// the result register is free. Throughput: one value per cycle while loading; while
// draining, one result per cycle (paced by result_ready) and no input. A failed set
// drains as one error result. Reset clears all valid flags, the error and the state.
module distinct_value_sorter_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  dvs_pkg::in_item_t sample,
    output logic              result_valid,
    input  logic              result_ready,
    output dvs_pkg::out_item_t result
);
    import dvs_pkg::*;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } state_t;

    state_t              state_reg;
    state_t              state_next;
    logic [STATUS_W-1:0] error_reg;
    logic [STATUS_W-1:0] error_next;
    logic                result_valid_reg;
    logic                result_valid_next;
    out_item_t           result_reg;
    out_item_t           result_next;

    entry_t              cell_entry [CAPACITY];
    logic [CAPACITY-1:0] cell_after;
    logic [CAPACITY-1:0] cell_equal;
    logic [CAPACITY-1:0] cell_valid;
    cell_op_t            cell_op;

    logic accept;
    logic duplicate;
    logic full;
    logic load_slot;
    logic final_load;

    // Chain of cells; the ends see an empty neighbor.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        entry_t prev_entry;
        entry_t next_entry;
        logic   prev_after;

        if (i == 0)
        begin : g_first
            assign prev_entry = '0;
            assign prev_after = 1'b0;
        end
        else
        begin : g_inner
            assign prev_entry = cell_entry[i-1];
            assign prev_after = cell_after[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_entry = '0;
        end
        else
        begin : g_body
            assign next_entry = cell_entry[i+1];
        end

        dvs_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .op           (cell_op),
            .sample_value (sample.sample_value),
            .prev_entry   (prev_entry),
            .prev_after   (prev_after),
            .next_entry   (next_entry),
            .entry        (cell_entry[i]),
            .after        (cell_after[i]),
            .equal        (cell_equal[i])
        );

        assign cell_valid[i] = cell_entry[i].valid;
    end

    // Handshake and set checks.
    assign sample_ready = (state_reg == ST_LOAD);
    assign accept       = sample_valid && sample_ready;
    assign duplicate    = |cell_equal;
    assign full         = cell_valid[CAPACITY-1];
    assign load_slot    = (state_reg == ST_DRAIN) && (!result_valid_reg || result_ready);
    assign final_load   = load_slot && ((error_reg != STATUS_OK) || !cell_valid[1]);

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Chain operation for this cycle.
    always_comb
    begin
        cell_op = CELL_HOLD;
        if (accept && (error_reg == STATUS_OK) && !duplicate && !full)
        begin
            cell_op = CELL_INSERT;
        end
        else if (load_slot)
        begin
            cell_op = (error_reg != STATUS_OK) ? CELL_CLEAR : CELL_SHIFT;
        end
    end

    // Control: error tracking, drain sequencing and the result register.
    always_comb
    begin
        state_next        = state_reg;
        error_next        = error_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        unique case (state_reg)
            ST_LOAD:
            begin
                if (accept)
                begin
                    // The first error of a set wins; the duplicate check comes first.
                    if (error_reg == STATUS_OK)
                    begin
                        if (duplicate)
                        begin
                            error_next = STATUS_DUPLICATE;
                        end
                        else if (full)
                        begin
                            error_next = STATUS_CAPACITY;
                        end
                    end
                    if (sample.end_of_set)
                    begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (load_slot)
                begin
                    result_valid_next = 1'b1;
                    if (error_reg != STATUS_OK)
                    begin
                        result_next.sorted_value = '0;
                        result_next.status       = error_reg;
                        result_next.last_out     = 1'b1;
                    end
                    else
                    begin
                        result_next.sorted_value = cell_entry[0].value;
                        result_next.status       = STATUS_OK;
                        result_next.last_out     = !cell_valid[1];
                    end
                    if (final_load)
                    begin
                        state_next = ST_LOAD;
                        error_next = STATUS_OK;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_LOAD;
            error_reg        <= STATUS_OK;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            state_reg        <= state_next;
            error_reg        <= error_next;
            result_valid_reg <= result_valid_next;
            result_reg       <= result_next;
        end
    end

    // Adjacent occupied cells must hold strictly ascending values.
    logic [CAPACITY-2:0] pair_ok;
    for (genvar i = 0; i < CAPACITY - 1; i++)
    begin : g_order
        assign pair_ok[i] = !cell_valid[i+1] || (cell_entry[i].value < cell_entry[i+1].value);
    end

    // The occupied cells always form an unbroken run starting at the first cell.
    assert property (@(posedge clk) disable iff (!rst_n)
        ((cell_valid + 1'b1) & cell_valid) == '0)
        else $error("Occupied cells are not contiguous.");

    // The chain stays sorted with no repeated value.
    assert property (@(posedge clk) disable iff (!rst_n)
        &pair_ok)
        else $error("Cell chain lost ascending order.");

    // An error result carries a zero value and closes the set.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (result.status != STATUS_OK)) |->
            ((result.sorted_value == '0) && result.last_out))
        else $error("Malformed error result.");

    // Once the final result of a set is loaded, the chain and the error are clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        final_load |=> ((cell_valid == '0) && (error_reg == STATUS_OK)
                        && (state_reg == ST_LOAD)))
        else $error("Sorter not cleared after the final result.");

endmodule

/* tb/distinct_value_sorter_core_tb.sv */
`timescale 1ns / 100ps
// Testbench for distinct_value_sorter_core: loads sets of values and checks each sorted drain.
// A directed table runs first, then random sets checked against a behavioral sorter.
// Depends on dvs_pkg and the distinct_value_sorter_core RTL.
module distinct_value_sorter_core_tb;
    import dvs_pkg::*;

    localparam int unsigned DEPTH           = 64;
    localparam int unsigned ITEM_TARGET     = 450;
    localparam int unsigned HOLD_OFF_CYCLES = 400;
    localparam int unsigned HOLD_OFF_FILL   = 48;
    localparam int unsigned WATCHDOG_LIMIT  = 3000;
    localparam int unsigned DRAIN_CYCLES    = 16;
    localparam int unsigned REPORT_LIMIT    = 10;
    localparam logic [VALUE_W-1:0] VALUE_MAX = 31'h7FFF_FFFF;

    // One row of stimulus; typed rows carry the single result they must produce.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               last;
        logic               typed;
        out_item_t          want;
    } stim_row_t;

    // Shapes of random sets.
    typedef enum int {
        SET_FULL,
        SET_OVERFLOW,
        SET_FULL_DUP,
        SET_SMALL,
        SET_SMALL_DUP
    } set_kind_t;

    // Value ranges used by small random sets.
    typedef enum int {
        VALS_WIDE,
        VALS_NARROW,
        VALS_TOP,
        VALS_LOW
    } value_mode_t;

    localparam out_item_t NO_WANT = '0;

    // Directed sets: extremes, duplicates, first error wins, and clearing between sets.
    localparam int unsigned DIRECTED_ROWS = 23;
    localparam stim_row_t DIRECTED [DIRECTED_ROWS] = '{
        '{31'd0,         1'b1, 1'b1, '{31'd0, STATUS_OK, 1'b1}},
        '{VALUE_MAX,     1'b1, 1'b1, '{VALUE_MAX, STATUS_OK, 1'b1}},
        '{31'd5,         1'b0, 1'b0, NO_WANT},
        '{VALUE_MAX,     1'b0, 1'b0, NO_WANT},
        '{31'd0,         1'b0, 1'b0, NO_WANT},
        '{31'h5555_5555, 1'b0, 1'b0, NO_WANT},
        '{31'h2AAA_AAAA, 1'b1, 1'b0, NO_WANT},
        '{31'd7,         1'b0, 1'b0, NO_WANT},
        '{31'd7,         1'b1, 1'b1, '{31'd0, STATUS_DUPLICATE, 1'b1}},
        '{31'd9,         1'b0, 1'b0, NO_WANT},
        '{31'd3,         1'b0, 1'b0, NO_WANT},
        '{31'd9,         1'b0, 1'b0, NO_WANT},
        '{31'd100,       1'b0, 1'b0, NO_WANT},
        '{31'd3,         1'b1, 1'b1, '{31'd0, STATUS_DUPLICATE, 1'b1}},
        '{31'd7,         1'b1, 1'b1, '{31'd7, STATUS_OK, 1'b1}},
        '{31'd40,        1'b0, 1'b0, NO_WANT},
        '{31'd30,        1'b0, 1'b0, NO_WANT},
        '{31'd20,        1'b0, 1'b0, NO_WANT},
        '{31'd10,        1'b1, 1'b0, NO_WANT},
        '{VALUE_MAX,     1'b0, 1'b0, NO_WANT},
        '{VALUE_MAX,     1'b1, 1'b1, '{31'd0, STATUS_DUPLICATE, 1'b1}},
        '{31'd1,         1'b0, 1'b0, NO_WANT},
        '{31'd0,         1'b1, 1'b0, NO_WANT}
    };

    logic      clk;
    logic      rst_n;
    logic      sample_valid;
    logic      sample_ready;
    in_item_t  sample;
    logic      result_valid;
    logic      result_ready;
    out_item_t result;

    stim_row_t           stim_q[$];
    out_item_t           expected_results_q[$];
    out_item_t           predicted_q[$];
    logic [VALUE_W-1:0]  held_q[$];
    logic [STATUS_W-1:0] set_status   = STATUS_OK;
    int unsigned         accepted_n   = 0;
    int unsigned         result_n     = 0;
    int unsigned         fault_count  = 0;
    int unsigned         quiet_cycles = 0;

    distinct_value_sorter_core #(
        .CAPACITY(DEPTH)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample_valid(sample_valid),
        .sample_ready(sample_ready),
        .sample      (sample),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Counts a failure and reports the first few of them.
    task automatic note_fault(input string what);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
        begin
            $display("%0t: %s", $time, what);
        end
    endtask

    // Sorter behavior: absorbs one accepted value and, on the closing value of a set,
    // leaves the results of that set in predicted_q.
    task automatic predict_sample(input in_item_t s);
        logic [VALUE_W-1:0] v;
        bit                 dup;
        int unsigned        pos;
        v   = s.sample_value;
        dup = 1'b0;
        pos = 0;
        predicted_q.delete();
        // Once a set has failed, its later values are ignored.
        if (set_status == STATUS_OK)
        begin
            foreach (held_q[k])
            begin
                if (held_q[k] == v)
                begin
                    dup = 1'b1;
                end
            end
            // The duplicate check takes precedence over a full store.
            if (dup)
            begin
                set_status = STATUS_DUPLICATE;
            end
            else if (held_q.size() >= DEPTH)
            begin
                set_status = STATUS_CAPACITY;
            end
            else
            begin
                while (pos < held_q.size() && held_q[pos] < v)
                begin
                    pos++;
                end
                held_q.insert(pos, v);
            end
        end
        // Closing value: one error result, or every held value in ascending order.
        if (s.end_of_set)
        begin
            if (set_status != STATUS_OK)
            begin
                predicted_q.insert(predicted_q.size(), '{'0, set_status, 1'b1});
            end
            else
            begin
                foreach (held_q[k])
                begin
                    predicted_q.insert(predicted_q.size(),
                                       '{held_q[k], STATUS_OK, (k == held_q.size() - 1)});
                end
            end
            held_q.delete();
            set_status = STATUS_OK;
        end
    endtask

    // Compares one result transaction with the oldest expectation.
    task automatic check_result(input out_item_t got);
        out_item_t want;
        result_n++;
        if (expected_results_q.size() == 0)
        begin
            note_fault($sformatf("unexpected result %0d: value %h status %0d last %0b",
                                 result_n, got.sorted_value, got.status, got.last_out));
            return;
        end
        want = expected_results_q.pop_front();
        if (got.sorted_value !== want.sorted_value || got.status !== want.status ||
            got.last_out !== want.last_out)
        begin
            note_fault($sformatf({"result %0d mismatch: expected value %h status %0d last %0b,",
                                  " got value %h status %0d last %0b"},
                                 result_n, want.sorted_value, want.status, want.last_out,
                                 got.sorted_value, got.status, got.last_out));
        end
    endtask

    // Builds the whole stimulus: the directed table followed by random sets.
    task automatic build_stimulus();
        logic [VALUE_W-1:0] set_vals[$];
        logic [VALUE_W-1:0] tmp;
        set_kind_t          kind;
        value_mode_t        mode;
        int unsigned        n_sets;
        int unsigned        i;
        int unsigned        j;
        int unsigned        extra;
        int unsigned        count;
        logic [31:0]        base;
        logic [31:0]        step;
        foreach (DIRECTED[r])
        begin
            stim_q.insert(stim_q.size(), DIRECTED[r]);
        end
        n_sets = 0;
        while (stim_q.size() < ITEM_TARGET)
        begin
            // The three large sets come first; small sets fill the rest.
            if (n_sets < 3)
            begin
                kind = set_kind_t'(n_sets);
            end
            else
            begin
                kind = ($urandom_range(0, 3) == 0) ? SET_SMALL_DUP : SET_SMALL;
            end
            set_vals.delete();
            base = $urandom;
            step = $urandom | 32'd1;
            case (kind) inside
                SET_FULL, SET_OVERFLOW, SET_FULL_DUP:
                begin
                    // An odd step keeps the values distinct modulo the value range.
                    extra = (kind == SET_OVERFLOW) ? $urandom_range(1, 2) : 0;
                    for (i = 0; i < DEPTH + extra; i++)
                    begin
                        set_vals.insert(set_vals.size(), VALUE_W'(base + i * step));
                    end
                    for (i = set_vals.size() - 1; i > 0; i--)
                    begin
                        j           = $urandom_range(0, i);
                        tmp         = set_vals[i];
                        set_vals[i] = set_vals[j];
                        set_vals[j] = tmp;
                    end
                    if (kind == SET_OVERFLOW && $urandom_range(0, 1) == 1)
                    begin
                        set_vals.insert(set_vals.size(), set_vals[0]);
                    end
                    if (kind == SET_FULL_DUP)
                    begin
                        set_vals.insert(set_vals.size(),
                                        set_vals[$urandom_range(0, DEPTH - 1)]);
                    end
                end
                default:
                begin
                    count = $urandom_range(1, 12);
                    mode  = value_mode_t'($urandom_range(0, 3));
                    for (i = 0; i < count; i++)
                    begin
                        case (mode)
                            VALS_WIDE:   tmp = VALUE_W'($urandom);
                            VALS_NARROW: tmp = VALUE_W'($urandom_range(0, 15));
                            VALS_TOP:    tmp = VALUE_MAX - VALUE_W'($urandom_range(0, 15));
                            default:     tmp = VALUE_W'($urandom_range(0, 63));
                        endcase
                        set_vals.insert(set_vals.size(), tmp);
                    end
                    // Repeat an earlier value of the set somewhere after it.
                    if (kind == SET_SMALL_DUP)
                    begin
                        i = $urandom_range(1, count);
                        j = $urandom_range(0, i - 1);
                        set_vals.insert(i, set_vals[j]);
                    end
                end
            endcase
            foreach (set_vals[k])
            begin
                stim_q.insert(stim_q.size(),
                              '{set_vals[k], (k == set_vals.size() - 1), 1'b0, NO_WANT});
            end
            n_sets++;
        end
    endtask

    // Monitor: predicts on every accepted input transaction, checks every result
    // transaction, and ends the run when nothing moves for too long.
    always @(posedge clk)
    begin : monitor
        stim_row_t row;
        bit        moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (sample_valid && sample_ready)
            begin
                row = stim_q[accepted_n];
                predict_sample(sample);
                if (row.typed)
                begin
                    expected_results_q.insert(expected_results_q.size(), row.want);
                end
                else
                begin
                    foreach (predicted_q[k])
                    begin
                        expected_results_q.insert(expected_results_q.size(), predicted_q[k]);
                    end
                end
                accepted_n++;
                moved = 1'b1;
            end
            if (result_valid && result_ready)
            begin
                check_result(result);
                moved = 1'b1;
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

    // Receiver: stalls on a pattern of its own and holds off once for a long stretch
    // while a large set is draining, so that the input side backs up.
    initial
    begin : receiver
        bit          held_off;
        int unsigned mode;
        int unsigned span;
        held_off     = 1'b0;
        result_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(16, 80);
            repeat (span)
            begin
                @(negedge clk);
                if (!held_off && result_valid && expected_results_q.size() >= HOLD_OFF_FILL)
                begin
                    held_off = 1'b1;
                    result_ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(negedge clk);
                end
                case (mode)
                    0:       result_ready <= 1'b1;
                    1:       result_ready <= ($urandom_range(0, 1) == 1);
                    2:       result_ready <= ($urandom_range(0, 3) == 0);
                    default: result_ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Sender: resets the block, offers every input transaction in bursts with random
    // gaps, then waits for the last results and gives the verdict.
    initial
    begin : sender
        int unsigned idx;
        int unsigned burst_left;
        int unsigned gap;
        rst_n        = 1'b0;
        sample_valid = 1'b0;
        sample       = '0;
        build_stimulus();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        idx        = 0;
        burst_left = 0;
        while (idx < stim_q.size())
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 24);
                gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0)
                begin
                    sample_valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            sample_valid <= 1'b1;
            sample       <= '{stim_q[idx].value, stim_q[idx].last};
            do
            begin
                @(negedge clk);
            end
            while (accepted_n <= idx);
            idx++;
            burst_left--;
        end
        sample_valid <= 1'b0;
        // Let the remaining results drain, then watch a little longer for strays.
        while (expected_results_q.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fault_count == 0 && expected_results_q.size() == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
